>>> rtl/core/onm_pkg.sv
// shared types and constants for the orientation matrix orthonormaliser
package onm_pkg;

    localparam int Q_W   = 32;
    localparam int VEC_W = 3 * Q_W;

    typedef logic signed [Q_W-1:0]   q16_t;
    typedef logic signed [2*Q_W-1:0] prod_t;

    localparam q16_t Q_ONE       = 32'sd65536;
    localparam q16_t Q_MINUS_ONE = -32'sd65536;

    typedef struct packed {
        q16_t x;
        q16_t y;
        q16_t z;
    } vec3_t;

    // which side component gets recomputed
    typedef enum logic [1:0] {
        FIX_Z,
        FIX_Y,
        FIX_X
    } fix_sel_t;

    typedef struct packed {
        q16_t fwd_x;
        q16_t fwd_y;
        q16_t fwd_z;
        q16_t side_x;
        q16_t side_y;
        q16_t side_z;
    } in_word_t;

    typedef struct packed {
        q16_t out_fwd_x;
        q16_t out_fwd_y;
        q16_t out_fwd_z;
        q16_t out_side_x;
        q16_t out_side_y;
        q16_t out_side_z;
        q16_t out_roof_x;
        q16_t out_roof_y;
        q16_t out_roof_z;
        logic math_error;
    } out_word_t;

endpackage

>>> rtl/core/onm_if.sv
// valid/ready channel interfaces for input and result words
interface onm_in_if;
    logic              valid;
    logic              ready;
    onm_pkg::in_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface onm_out_if;
    logic               valid;
    logic               ready;
    onm_pkg::out_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/onm_sqrt.sv
// pipelined integer square root, one result bit per stage
module onm_sqrt #(
    parameter int SB_W = 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [63:0]     rad,
    input  logic [SB_W-1:0] in_sb,
    output logic            out_valid,
    output logic [31:0]     root,
    output logic [SB_W-1:0] out_sb
);
    localparam int RW    = 32;
    localparam int RAD_W = 2 * RW;
    localparam int REM_W = RW + 4;

    logic              valid_reg [0:RW];
    logic [SB_W-1:0]   sb_reg    [0:RW];
    logic [RAD_W-1:0]  rad_reg   [0:RW];
    logic [REM_W-1:0]  rem_reg   [0:RW];
    logic [RW-1:0]     root_reg  [0:RW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= RW; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k <= RW; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sb_reg[0]   <= in_sb;
            rad_reg[0]  <= rad;
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            for (int k = 1; k <= RW; k++)
            begin
                sb_reg[k] <= sb_reg[k-1];
            end
        end
    end

    for (genvar k = 0; k < RW; k++)
    begin : g_step
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        logic [REM_W-1:0] rem_next;
        logic [RW-1:0]    root_next;

        always_comb
        begin
            rem_sh = {rem_reg[k][REM_W-3:0], rad_reg[k][RAD_W-1 -: 2]};
            trial  = REM_W'({root_reg[k], 2'b01});
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[k][RW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_reg[k][RW-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]  <= rem_next;
                root_reg[k+1] <= root_next;
                rad_reg[k+1]  <= rad_reg[k] << 2;
            end
        end
    end

    assign out_valid = valid_reg[RW];
    assign root      = root_reg[RW];
    assign out_sb    = sb_reg[RW];

endmodule

>>> rtl/core/onm_div.sv
// pipelined saturating signed divider, lanes share one divisor
module onm_div #(
    parameter int NUM_W = 48,
    parameter int LANES = 1,
    parameter int SB_W  = 1
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic signed [NUM_W-1:0] num [LANES],
    input  logic [31:0]             den_mag,
    input  logic                    den_neg,
    input  logic [SB_W-1:0]         in_sb,
    output logic                    out_valid,
    output onm_pkg::q16_t           quo [LANES],
    output logic                    err,
    output logic [SB_W-1:0]         out_sb
);
    localparam int QW   = 32;
    localparam int LAST = QW + 2;

    logic                 valid_reg [0:LAST];
    logic [SB_W-1:0]      sb_reg    [0:LAST];
    logic [QW-1:0]        den_reg   [0:LAST-1];
    logic                 neg_reg   [0:LAST-1][LANES];
    logic [NUM_W-1:0]     un_reg    [LANES];
    logic [QW-1:0]        rem_reg   [1:LAST-1][LANES];
    logic [QW-1:0]        low_reg   [1:LAST-1][LANES];
    logic [QW-1:0]        q_reg     [1:LAST-1][LANES];
    logic                 ovf_reg   [1:LAST-1][LANES];
    onm_pkg::q16_t        quo_reg   [LANES];
    logic                 err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= LAST; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k <= LAST; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sb_reg[0]  <= in_sb;
            den_reg[0] <= den_mag;
            for (int l = 0; l < LANES; l++)
            begin
                neg_reg[0][l] <= num[l][NUM_W-1] ^ den_neg;
            end
            for (int k = 1; k <= LAST; k++)
            begin
                sb_reg[k] <= sb_reg[k-1];
            end
            for (int k = 1; k < LAST; k++)
            begin
                den_reg[k] <= den_reg[k-1];
                for (int l = 0; l < LANES; l++)
                begin
                    neg_reg[k][l] <= neg_reg[k-1][l];
                end
            end
            err_reg <= (den_reg[LAST-1] == '0);
        end
    end

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        logic [NUM_W-1:0] hi;
        logic [QW-1:0]    q_fin;
        onm_pkg::q16_t    quo_next;

        assign hi = un_reg[l] >> QW;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                un_reg[l]     <= num[l][NUM_W-1] ? NUM_W'(-num[l]) : NUM_W'(num[l]);
                ovf_reg[1][l] <= (hi >= NUM_W'(den_reg[0]));
                rem_reg[1][l] <= QW'(hi);
                low_reg[1][l] <= un_reg[l][QW-1:0];
                q_reg[1][l]   <= '0;
            end
        end

        for (genvar k = 1; k <= QW; k++)
        begin : g_step
            logic [QW:0]   r2;
            logic [QW:0]   dd;
            logic          fit;
            logic [QW-1:0] rem_next;

            assign r2       = {rem_reg[k][l], low_reg[k][l][QW-1]};
            assign dd       = {1'b0, den_reg[k]};
            assign fit      = (r2 >= dd);
            assign rem_next = fit ? QW'(r2 - dd) : QW'(r2);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k+1][l] <= rem_next;
                    low_reg[k+1][l] <= {low_reg[k][l][QW-2:0], 1'b0};
                    q_reg[k+1][l]   <= {q_reg[k][l][QW-2:0], fit};
                    ovf_reg[k+1][l] <= ovf_reg[k][l];
                end
            end
        end

        assign q_fin = q_reg[LAST-1][l];

        always_comb
        begin
            if (den_reg[LAST-1] == '0)
            begin
                quo_next = '0;
            end
            else if (neg_reg[LAST-1][l])
            begin
                if (ovf_reg[LAST-1][l] || q_fin > 32'h8000_0000)
                begin
                    quo_next = onm_pkg::q16_t'(32'h8000_0000);
                end
                else
                begin
                    quo_next = onm_pkg::q16_t'(-q_fin);
                end
            end
            else
            begin
                if (ovf_reg[LAST-1][l] || q_fin[QW-1])
                begin
                    quo_next = onm_pkg::q16_t'(32'h7FFF_FFFF);
                end
                else
                begin
                    quo_next = onm_pkg::q16_t'(q_fin);
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quo_reg[l] <= quo_next;
            end
        end

        assign quo[l] = quo_reg[l];
    end

    assign out_valid = valid_reg[LAST];
    assign err       = err_reg;
    assign out_sb    = sb_reg[LAST];

endmodule

>>> rtl/core/onm_norm.sv
// pipelined vector normaliser: squares, sum, square root, three divides
module onm_norm #(
    parameter int SB_W = 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  onm_pkg::vec3_t  vec,
    input  logic [SB_W-1:0] in_sb,
    output logic            out_valid,
    output onm_pkg::vec3_t  out_vec,
    output logic            err,
    output logic [SB_W-1:0] out_sb
);
    localparam int NUM_W = 48;
    localparam int FRAC  = 16;

    onm_pkg::q16_t   comp [3];
    logic [31:0]     mag  [3];

    logic            v0_reg;
    logic [63:0]     sq_reg [3];
    onm_pkg::vec3_t  vec0_reg;
    logic [SB_W-1:0] sb0_reg;

    logic            v1_reg;
    logic [63:0]     sum_reg;
    onm_pkg::vec3_t  vec1_reg;
    logic [SB_W-1:0] sb1_reg;

    logic                  sq_valid;
    logic [31:0]           len;
    onm_pkg::vec3_t        sq_vec;
    logic [SB_W-1:0]       sq_sb;
    logic signed [NUM_W-1:0] div_num [3];
    onm_pkg::q16_t         div_quo [3];

    assign comp[0] = vec.x;
    assign comp[1] = vec.y;
    assign comp[2] = vec.z;

    for (genvar i = 0; i < 3; i++)
    begin : g_mag
        assign mag[i] = comp[i][31] ? 32'(-comp[i]) : 32'(comp[i]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i] <= 64'(mag[i]) * 64'(mag[i]);
            end
            vec0_reg <= vec;
            sb0_reg  <= in_sb;
            sum_reg  <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            vec1_reg <= vec0_reg;
            sb1_reg  <= sb0_reg;
        end
    end

    onm_sqrt #(
        .SB_W (onm_pkg::VEC_W + SB_W)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v1_reg),
        .rad       (sum_reg),
        .in_sb     ({vec1_reg, sb1_reg}),
        .out_valid (sq_valid),
        .root      (len),
        .out_sb    ({sq_vec, sq_sb})
    );

    // c * 2^16, sign kept
    assign div_num[0] = {sq_vec.x, {FRAC{1'b0}}};
    assign div_num[1] = {sq_vec.y, {FRAC{1'b0}}};
    assign div_num[2] = {sq_vec.z, {FRAC{1'b0}}};

    // zero length gives a zero divisor, hence zero vector and error
    onm_div #(
        .NUM_W (NUM_W),
        .LANES (3),
        .SB_W  (SB_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .num       (div_num),
        .den_mag   (len),
        .den_neg   (1'b0),
        .in_sb     (sq_sb),
        .out_valid (out_valid),
        .quo       (div_quo),
        .err       (err),
        .out_sb    (out_sb)
    );

    assign out_vec.x = div_quo[0];
    assign out_vec.y = div_quo[1];
    assign out_vec.z = div_quo[2];

endmodule

>>> rtl/core/orientation_matrix_orthonormalise.sv
// One matrix word enters per clock and one result word leaves per clock while
// out_ch is not stalled. The pipeline is made up of the two normalisers (squares,
// a 33-stage square root, a 35-stage divider each), the 35-stage divider that
// recomputes the perpendicular side component, and the product and cross-product
// stages. in_ch.ready drops only while a result waits on a stalled out_ch, and
// then the whole pipeline holds.
module orientation_matrix_orthonormalise (
    input  logic            clk,
    input  logic            rst_n,
    onm_in_if.sink          in_ch,
    onm_out_if.source       out_ch
);
    localparam int NUM_W = 64;
    localparam int FRAC  = 16;

    typedef struct packed {
        onm_pkg::vec3_t   f;
        onm_pkg::vec3_t   s;
        onm_pkg::fix_sel_t sel;
        logic             err;
    } perp_sb_t;

    typedef struct packed {
        onm_pkg::vec3_t f;
        logic           err;
    } side_sb_t;

    function automatic onm_pkg::q16_t shr_trunc(input onm_pkg::prod_t d);
        onm_pkg::prod_t adj;
        adj = d + (d[63] ? 64'sd65535 : 64'sd0);
        return onm_pkg::q16_t'(adj >>> FRAC);
    endfunction

    logic en;

    onm_pkg::vec3_t in_f;
    onm_pkg::vec3_t in_s;

    logic           nf_valid;
    onm_pkg::vec3_t nf_vec;
    logic           nf_err;
    onm_pkg::vec3_t nf_side;

    logic              p1_valid_reg;
    onm_pkg::vec3_t    p1_f_reg;
    onm_pkg::vec3_t    p1_s_reg;
    onm_pkg::fix_sel_t p1_sel_reg;
    logic              p1_err_reg;
    onm_pkg::prod_t    p1_pa_reg;
    onm_pkg::prod_t    p1_pb_reg;
    logic [31:0]       p1_dmag_reg;
    logic              p1_dneg_reg;

    onm_pkg::fix_sel_t sel_next;
    onm_pkg::q16_t     ma_f, ma_s, mb_f, mb_s, den_next;

    logic                    p2_valid_reg;
    perp_sb_t                p2_sb_reg;
    logic signed [NUM_W-1:0] p2_num_reg [1];
    logic [31:0]             p2_dmag_reg;
    logic                    p2_dneg_reg;

    logic          pd_valid;
    onm_pkg::q16_t pd_quo [1];
    logic          pd_err;
    perp_sb_t      pd_sb;

    onm_pkg::vec3_t s_fix;
    side_sb_t       ns_in_sb;

    logic           ns_valid;
    onm_pkg::vec3_t ns_vec;
    logic           ns_err;
    side_sb_t       ns_sb;

    logic           c1_valid_reg;
    onm_pkg::prod_t c1_prod_reg [6];
    onm_pkg::vec3_t c1_f_reg;
    onm_pkg::vec3_t c1_s_reg;
    logic           c1_err_reg;

    logic               out_valid_reg;
    onm_pkg::out_word_t out_reg;

    assign en           = !out_valid_reg || out_ch.ready;
    assign in_ch.ready  = en;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_reg;

    assign in_f = '{x: in_ch.data.fwd_x, y: in_ch.data.fwd_y, z: in_ch.data.fwd_z};
    assign in_s = '{x: in_ch.data.side_x, y: in_ch.data.side_y, z: in_ch.data.side_z};

    onm_norm #(
        .SB_W (onm_pkg::VEC_W)
    ) u_norm_fwd (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_ch.valid),
        .vec       (in_f),
        .in_sb     (in_s),
        .out_valid (nf_valid),
        .out_vec   (nf_vec),
        .err       (nf_err),
        .out_sb    (nf_side)
    );

    // pick the side component to recompute and its two product terms
    always_comb
    begin
        if (nf_vec.x > onm_pkg::Q_MINUS_ONE && nf_vec.x < onm_pkg::Q_ONE)
        begin
            if (nf_vec.y > onm_pkg::Q_MINUS_ONE && nf_vec.y < onm_pkg::Q_ONE)
            begin
                sel_next = onm_pkg::FIX_Z;
            end
            else
            begin
                sel_next = onm_pkg::FIX_Y;
            end
        end
        else
        begin
            sel_next = onm_pkg::FIX_X;
        end

        case (sel_next)
            onm_pkg::FIX_Z:
            begin
                ma_f = nf_vec.x; ma_s = nf_side.x;
                mb_f = nf_vec.y; mb_s = nf_side.y;
                den_next = nf_vec.z;
            end
            onm_pkg::FIX_Y:
            begin
                ma_f = nf_vec.x; ma_s = nf_side.x;
                mb_f = nf_vec.z; mb_s = nf_side.z;
                den_next = nf_vec.y;
            end
            default:
            begin
                ma_f = nf_vec.y; ma_s = nf_side.y;
                mb_f = nf_vec.z; mb_s = nf_side.z;
                den_next = nf_vec.x;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            c1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p1_valid_reg  <= nf_valid;
            p2_valid_reg  <= p1_valid_reg;
            c1_valid_reg  <= ns_valid;
            out_valid_reg <= c1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_f_reg    <= nf_vec;
            p1_s_reg    <= nf_side;
            p1_sel_reg  <= sel_next;
            p1_err_reg  <= nf_err;
            p1_pa_reg   <= onm_pkg::prod_t'(ma_f) * onm_pkg::prod_t'(ma_s);
            p1_pb_reg   <= onm_pkg::prod_t'(mb_f) * onm_pkg::prod_t'(mb_s);
            p1_dmag_reg <= den_next[31] ? 32'(-den_next) : 32'(den_next);
            p1_dneg_reg <= den_next[31];

            p2_sb_reg     <= '{f: p1_f_reg, s: p1_s_reg, sel: p1_sel_reg, err: p1_err_reg};
            p2_num_reg[0] <= -(p1_pa_reg + p1_pb_reg);
            p2_dmag_reg   <= p1_dmag_reg;
            p2_dneg_reg   <= p1_dneg_reg;
        end
    end

    onm_div #(
        .NUM_W (NUM_W),
        .LANES (1),
        .SB_W  ($bits(perp_sb_t))
    ) u_perp_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (p2_valid_reg),
        .num       (p2_num_reg),
        .den_mag   (p2_dmag_reg),
        .den_neg   (p2_dneg_reg),
        .in_sb     (p2_sb_reg),
        .out_valid (pd_valid),
        .quo       (pd_quo),
        .err       (pd_err),
        .out_sb    (pd_sb)
    );

    always_comb
    begin
        s_fix = pd_sb.s;
        case (pd_sb.sel)
            onm_pkg::FIX_Z: s_fix.z = pd_quo[0];
            onm_pkg::FIX_Y: s_fix.y = pd_quo[0];
            onm_pkg::FIX_X: s_fix.x = pd_quo[0];
            default:        s_fix   = pd_sb.s;
        endcase
    end

    assign ns_in_sb = '{f: pd_sb.f, err: pd_sb.err | pd_err};

    onm_norm #(
        .SB_W ($bits(side_sb_t))
    ) u_norm_side (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pd_valid),
        .vec       (s_fix),
        .in_sb     (ns_in_sb),
        .out_valid (ns_valid),
        .out_vec   (ns_vec),
        .err       (ns_err),
        .out_sb    (ns_sb)
    );

    // roof = side x forward
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_prod_reg[0] <= onm_pkg::prod_t'(ns_vec.y) * onm_pkg::prod_t'(ns_sb.f.z);
            c1_prod_reg[1] <= onm_pkg::prod_t'(ns_vec.z) * onm_pkg::prod_t'(ns_sb.f.y);
            c1_prod_reg[2] <= onm_pkg::prod_t'(ns_vec.z) * onm_pkg::prod_t'(ns_sb.f.x);
            c1_prod_reg[3] <= onm_pkg::prod_t'(ns_vec.x) * onm_pkg::prod_t'(ns_sb.f.z);
            c1_prod_reg[4] <= onm_pkg::prod_t'(ns_vec.x) * onm_pkg::prod_t'(ns_sb.f.y);
            c1_prod_reg[5] <= onm_pkg::prod_t'(ns_vec.y) * onm_pkg::prod_t'(ns_sb.f.x);
            c1_f_reg       <= ns_sb.f;
            c1_s_reg       <= ns_vec;
            c1_err_reg     <= ns_sb.err | ns_err;

            out_reg.out_fwd_x  <= c1_f_reg.x;
            out_reg.out_fwd_y  <= c1_f_reg.y;
            out_reg.out_fwd_z  <= c1_f_reg.z;
            out_reg.out_side_x <= c1_s_reg.x;
            out_reg.out_side_y <= c1_s_reg.y;
            out_reg.out_side_z <= c1_s_reg.z;
            out_reg.out_roof_x <= shr_trunc(c1_prod_reg[0] - c1_prod_reg[1]);
            out_reg.out_roof_y <= shr_trunc(c1_prod_reg[2] - c1_prod_reg[3]);
            out_reg.out_roof_z <= shr_trunc(c1_prod_reg[4] - c1_prod_reg[5]);
            out_reg.math_error <= c1_err_reg;
        end
    end

endmodule

>>> rtl/core/onm_checker.sv
// port-level checks for the orthonormaliser, bound to the top level
module onm_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input onm_pkg::out_word_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("result word changed while stalled");

    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input refused without a downstream stall");

    a_zero_fwd_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.out_fwd_x == '0 && out_data.out_fwd_y == '0
        && out_data.out_fwd_z == '0 |-> out_data.math_error)
        else $error("zero forward row without error flag");

    a_fwd_unit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.out_fwd_x >= onm_pkg::Q_MINUS_ONE
        && out_data.out_fwd_x <= onm_pkg::Q_ONE
        && out_data.out_fwd_y >= onm_pkg::Q_MINUS_ONE
        && out_data.out_fwd_y <= onm_pkg::Q_ONE
        && out_data.out_fwd_z >= onm_pkg::Q_MINUS_ONE
        && out_data.out_fwd_z <= onm_pkg::Q_ONE)
        else $error("normalised forward component beyond unit range");

endmodule

bind orientation_matrix_orthonormalise onm_checker u_onm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
);
